>>> sv/base64_stream_codec_unit_macros.svh
// Assertion macros for the Base64 stream codec.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef BASE64_STREAM_CODEC_UNIT_MACROS_SVH
`define BASE64_STREAM_CODEC_UNIT_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define B64SC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition in the cycle after its trigger
`define B64SC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/b64sc_pkg.sv
// Shared types, codes and alphabet functions for the Base64 stream codec.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package b64sc_pkg;

   localparam logic       MODE_ENCODE     = 1'b0;
   localparam logic       MODE_DECODE     = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
   localparam logic [1:0] STATUS_BAD_LEN  = 2'd2;

   localparam logic [7:0] PAD_CHAR        = 8'h3d;

   localparam int MAX_RESULTS  = 4;
   localparam int RES_IDX_W    = $clog2(MAX_RESULTS);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_IDX_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   // One result beat
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       out_last;
      logic [1:0] status;
   } result_type;

   // All results caused by one input beat
   typedef struct packed {
      logic [RES_IDX_W-1:0]             last_idx;
      result_type [MAX_RESULTS-1:0]     res;
   } job_type;

   // Map a six-bit value to its alphabet character
   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] w;
      w = {2'b00, v};
      if (w < 8'd26)      return 8'h41 + w;
      else if (w < 8'd52) return 8'h61 + (w - 8'd26);
      else if (w < 8'd62) return 8'h30 + (w - 8'd52);
      else if (w == 8'd62) return 8'h2b;
      else                return 8'h2f;
   endfunction

   // Map a character to {valid, six-bit value}
   function automatic logic [6:0] char_sextet(input logic [7:0] c);
      logic [7:0] w;
      w = 8'h00;
      if (c >= 8'h41 && c <= 8'h5a) begin
         w = c - 8'h41;
         return {1'b1, w[5:0]};
      end
      if (c >= 8'h61 && c <= 8'h7a) begin
         w = c - 8'h61 + 8'd26;
         return {1'b1, w[5:0]};
      end
      if (c >= 8'h30 && c <= 8'h39) begin
         w = c - 8'h30 + 8'd52;
         return {1'b1, w[5:0]};
      end
      if (c == 8'h2b) return {1'b1, 6'd62};
      if (c == 8'h2f) return {1'b1, 6'd63};
      return 7'd0;
   endfunction

endpackage

>>> sv/b64sc_front.sv
// Front end of the Base64 codec: accepts input beats, keeps message state
// and builds the list of results for each beat. Depends on b64sc_pkg.
`timescale 1ns / 1ps

module b64sc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_en,
   input  logic              csr_write_data,
   input  logic              req_valid,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last,
   output logic              req_stall,
   input  logic              q_full,
   output logic              job_push,
   output b64sc_pkg::job_type job_data
);
   import b64sc_pkg::*;

   logic        mode_ff;
   logic [15:0] store_ff, store_in;
   logic [2:0]  bit_count_ff, bit_count_in;
   logic [1:0]  group_ff, group_in;
   logic        pad_ff, pad_in;
   logic        err_ff, err_in;

   logic        accept;
   logic [2:0]  n;
   logic [7:0]  b0, b1, b2;
   logic [6:0]  lookup;
   logic [11:0] wide;
   logic [1:0]  st;
   job_type     job;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign lookup    = char_sextet(req_data_byte);
   assign wide      = {store_ff[5:0], lookup[5:0]};

   // Build results and next message state for the offered beat
   always_comb begin
      store_in     = store_ff;
      bit_count_in = bit_count_ff;
      group_in     = group_ff;
      pad_in       = pad_ff;
      err_in       = err_ff;
      job          = '0;
      n            = 3'd0;
      b0           = 8'h00;
      b1           = 8'h00;
      b2           = req_data_byte;
      st           = STATUS_OK;
      if (mode_ff == MODE_ENCODE) begin
         if (group_ff == 2'd2) begin
            // full group: four characters
            b0 = store_ff[15:8];
            b1 = store_ff[7:0];
            job.res[0] = '{sextet_char(b0[7:2]), 1'b1, 1'b0, STATUS_OK};
            job.res[1] = '{sextet_char({b0[1:0], b1[7:4]}), 1'b1, 1'b0, STATUS_OK};
            job.res[2] = '{sextet_char({b1[3:0], b2[7:6]}), 1'b1, 1'b0, STATUS_OK};
            job.res[3] = '{sextet_char(b2[5:0]), 1'b1, req_last, STATUS_OK};
            n        = 3'd4;
            group_in = 2'd0;
            store_in = 16'h0000;
         end else begin
            store_in = {store_ff[7:0], req_data_byte};
            group_in = group_ff + 2'd1;
            if (req_last) begin
               // flush a partial group with padding
               if (group_in == 2'd1) begin
                  b0 = req_data_byte;
                  b1 = 8'h00;
               end else begin
                  b0 = store_ff[7:0];
                  b1 = req_data_byte;
               end
               job.res[0] = '{sextet_char(b0[7:2]), 1'b1, 1'b0, STATUS_OK};
               job.res[1] = '{sextet_char({b0[1:0], b1[7:4]}), 1'b1, 1'b0, STATUS_OK};
               if (group_in == 2'd2)
                  job.res[2] = '{sextet_char({b1[3:0], 2'b00}), 1'b1, 1'b0, STATUS_OK};
               else
                  job.res[2] = '{PAD_CHAR, 1'b1, 1'b0, STATUS_OK};
               job.res[3] = '{PAD_CHAR, 1'b1, 1'b1, STATUS_OK};
               n = 3'd4;
            end
         end
      end else begin
         group_in = group_ff + 2'd1;
         if (!pad_ff && !err_ff) begin
            if (req_data_byte == PAD_CHAR) begin
               pad_in = 1'b1;
            end else if (!lookup[6]) begin
               err_in = 1'b1;
               if (!req_last) begin
                  job.res[0] = '{8'h00, 1'b0, 1'b0, STATUS_BAD_CHAR};
                  n = 3'd1;
               end
            end else begin
               // pack the sextet; emit a byte once eight bits are held
               case (bit_count_ff)
                  3'd2: begin
                     job.res[0]   = '{wide[7:0], 1'b1, 1'b0, STATUS_OK};
                     n            = 3'd1;
                     store_in     = 16'h0000;
                     bit_count_in = 3'd0;
                  end
                  3'd4: begin
                     job.res[0]   = '{wide[9:2], 1'b1, 1'b0, STATUS_OK};
                     n            = 3'd1;
                     store_in     = {14'h0000, wide[1:0]};
                     bit_count_in = 3'd2;
                  end
                  3'd6: begin
                     job.res[0]   = '{wide[11:4], 1'b1, 1'b0, STATUS_OK};
                     n            = 3'd1;
                     store_in     = {12'h000, wide[3:0]};
                     bit_count_in = 3'd4;
                  end
                  default: begin
                     store_in     = {10'h000, lookup[5:0]};
                     bit_count_in = 3'd6;
                  end
               endcase
            end
         end
         if (req_last) begin
            // closing status beat
            if (group_in != 2'd0)
               st = STATUS_BAD_LEN;
            else if (err_in)
               st = STATUS_BAD_CHAR;
            job.res[n[RES_IDX_W-1:0]] = '{8'h00, 1'b0, 1'b1, st};
            n = n + 3'd1;
         end
      end
      if (req_last) begin
         store_in     = 16'h0000;
         bit_count_in = 3'd0;
         group_in     = 2'd0;
         pad_in       = 1'b0;
         err_in       = 1'b0;
      end
      job.last_idx = n[RES_IDX_W-1:0] - 2'd1;
   end

   assign job_push = accept && (n != 3'd0);
   assign job_data = job;

   // Hold mode; advance message state on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_ENCODE;
         store_ff     <= 16'h0000;
         bit_count_ff <= 3'd0;
         group_ff     <= 2'd0;
         pad_ff       <= 1'b0;
         err_ff       <= 1'b0;
      end else if (csr_write_en) begin
         mode_ff      <= csr_write_data;
         store_ff     <= 16'h0000;
         bit_count_ff <= 3'd0;
         group_ff     <= 2'd0;
         pad_ff       <= 1'b0;
         err_ff       <= 1'b0;
      end else if (accept) begin
         store_ff     <= store_in;
         bit_count_ff <= bit_count_in;
         group_ff     <= group_in;
         pad_ff       <= pad_in;
         err_ff       <= err_in;
      end
   end

endmodule

>>> sv/b64sc_queue.sv
// Short job queue between the front and back of the Base64 codec.
// Depends on b64sc_pkg for the job type and depth.
`timescale 1ns / 1ps

module b64sc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64sc_pkg::job_type push_data,
   input  logic              pop,
   output b64sc_pkg::job_type pop_data,
   output logic              full,
   output logic              empty
);
   import b64sc_pkg::*;

   job_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0]  wr_ptr_ff;
   logic [QUEUE_IDX_W-1:0]  rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]  count_ff;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // Store pushed jobs
   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= push_data;
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)
            count_ff <= count_ff + 1'b1;
         else if (pop && !push)
            count_ff <= count_ff - 1'b1;
      end
   end

endmodule

>>> sv/b64sc_back.sv
// Back end of the Base64 codec: takes jobs from the queue and sends their
// results one beat per cycle while rsp is not stalled, through an output register. Depends on b64sc_pkg.
`timescale 1ns / 1ps

module b64sc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  b64sc_pkg::job_type q_data,
   output logic              q_pop,
   output logic              busy,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_out_valid,
   output logic              rsp_out_last,
   output logic [1:0]        rsp_status
);
   import b64sc_pkg::*;

   job_type                cur_ff;
   logic [RES_IDX_W-1:0]   idx_ff;
   logic                   busy_ff;
   logic                   rsp_valid_ff;
   result_type             rsp_ff;

   logic out_ready;
   logic emit;
   logic done;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign emit      = busy_ff && out_ready;
   assign done      = emit && (idx_ff == cur_ff.last_idx);
   assign q_pop     = !q_empty && (!busy_ff || done);
   assign busy      = busy_ff;

   // Load the next job as the current one finishes
   always_ff @(posedge clock) begin
      if (q_pop)
         cur_ff <= q_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (q_pop) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (done) begin
         busy_ff <= 1'b0;
      end else if (emit) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // Output register: hold while stalled, drop once taken
   always_ff @(posedge clock) begin
      if (emit)
         rsp_ff <= cur_ff.res[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (emit)
         rsp_valid_ff <= 1'b1;
      else if (!rsp_stall)
         rsp_valid_ff <= 1'b0;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_ff.out_byte;
   assign rsp_out_valid = rsp_ff.out_valid;
   assign rsp_out_last  = rsp_ff.out_last;
   assign rsp_status    = rsp_ff.status;

endmodule

>>> sv/base64_stream_codec_unit.sv
// Channel   Handshake              Payload
// req       req_valid / req_stall  req_data_byte, req_last
// rsp       rsp_valid / rsp_stall  rsp_out_byte, rsp_out_valid, rsp_out_last, rsp_status
// csr       csr_write_en           csr_write_data (mode: 0 encode, 1 decode)
//
// An input beat is taken every cycle while the four-entry job queue has room.
// The back end sends one result per cycle while rsp is not stalled, so an encode
// beat with a full group yields four results and a decode beat at most two.
// The first result of a beat passes the queue entry, the job register and the
// output register. Synchronous reset clears control state; no clearing pass.
// A stalled rsp holds its beat; req_stall rises only when the queue is full.
`timescale 1ns / 1ps
`include "base64_stream_codec_unit_macros.svh"

module base64_stream_codec_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_en,
   input  logic       csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_valid,
   output logic       rsp_out_last,
   output logic [1:0] rsp_status
);
   import b64sc_pkg::*;

   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;
   logic    back_busy;
   logic    status_only;
   logic    status_marked;
   job_type push_job;
   job_type pop_job;

   // Accept and classify beats
   b64sc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_data_byte  (req_data_byte),
      .req_last       (req_last),
      .req_stall      (req_stall),
      .q_full         (q_full),
      .job_push       (q_push),
      .job_data       (push_job)
   );

   // Decouple front from back
   b64sc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_job),
      .pop       (q_pop),
      .pop_data  (pop_job),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Send results
   b64sc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_data        (pop_job),
      .q_pop         (q_pop),
      .busy          (back_busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_valid (rsp_out_valid),
      .rsp_out_last  (rsp_out_last),
      .rsp_status    (rsp_status)
   );

   // Classify a status-only result beat
   assign status_only   = rsp_valid && !rsp_out_valid;
   assign status_marked = rsp_out_last || (rsp_status != STATUS_OK);

   `B64SC_ASSERT_SAME(a_no_push_when_full, q_full, !q_push, "job pushed into a full queue")
   `B64SC_ASSERT_NEXT(a_back_picks_up, !q_empty && !back_busy, back_busy, "job left waiting")
   `B64SC_ASSERT_SAME(a_status_beat, status_only, status_marked, "empty status beat")

endmodule

>>> test/tb.sv
// Self-checking testbench for base64_stream_codec_unit: encode and decode traffic
// against a cycle-free model of the codec kept in a scoreboard class.
// Depends on b64sc_pkg for the result type, mode, status and pad codes.
`timescale 1ns / 1ps

module tb;
   import b64sc_pkg::*;

   localparam int LIMIT_CYCLES  = 300000;
   localparam int SETTLE_CYCLES = 24;
   localparam int LONG_HOLD     = 120;
   localparam int REPORT_MAX    = 10;

   typedef logic [7:0] byte_queue_type[$];

   // Expected output beats of the codec, predicted per accepted input beat
   class codec_scoreboard;
      logic        mode;
      logic [15:0] held_bits;
      int          held_count;
      logic [1:0]  group_pos;
      bit          pad_seen;
      bit          bad_seen;
      result_type  coded_out[$];
      int          mismatches;

      function new();
         mode = MODE_ENCODE;
         mismatches = 0;
         clear_message();
      endfunction

      function void clear_message();
         held_bits  = '0;
         held_count = 0;
         group_pos  = '0;
         pad_seen   = 0;
         bad_seen   = 0;
      endfunction

      function void set_mode(logic m);
         mode = m;
         clear_message();
      endfunction

      // Alphabet position to character
      function logic [7:0] b64_char(logic [5:0] v);
         if (v < 6'd26) return 8'h41 + 8'(v);
         if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
         if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
         return (v == 6'd62) ? 8'h2b : 8'h2f;
      endfunction

      // Character to alphabet position, -1 when outside the alphabet
      function int b64_value(logic [7:0] c);
         for (int i = 0; i < 64; i++) begin
            if (b64_char(6'(i)) == c) return i;
         end
         return -1;
      endfunction

      function void push_result(logic [7:0] b, logic v, logic l, logic [1:0] st);
         result_type r;
         r.out_byte  = b;
         r.out_valid = v;
         r.out_last  = l;
         r.status    = st;
         coded_out.push_back(r);
      endfunction

      function void predict_from_byte(logic [7:0] b, logic l);
         logic [7:0] b0;
         logic [7:0] b1;
         logic [1:0] st;
         int         v;
         if (mode == MODE_ENCODE) begin
            // full group: four characters
            if (group_pos == 2'd2) begin
               b0 = held_bits[15:8];
               b1 = held_bits[7:0];
               push_result(b64_char(b0[7:2]), 1'b1, 1'b0, STATUS_OK);
               push_result(b64_char({b0[1:0], b1[7:4]}), 1'b1, 1'b0, STATUS_OK);
               push_result(b64_char({b1[3:0], b[7:6]}), 1'b1, 1'b0, STATUS_OK);
               push_result(b64_char(b[5:0]), 1'b1, l, STATUS_OK);
               group_pos = '0;
               held_bits = '0;
            end else begin
               held_bits = {held_bits[7:0], b};
               group_pos++;
            end
            // flush a partial group with padding
            if (l) begin
               if (group_pos != 2'd0) begin
                  if (group_pos == 2'd1) begin
                     b0 = held_bits[7:0];
                     b1 = 8'h00;
                  end else begin
                     b0 = held_bits[15:8];
                     b1 = held_bits[7:0];
                  end
                  push_result(b64_char(b0[7:2]), 1'b1, 1'b0, STATUS_OK);
                  push_result(b64_char({b0[1:0], b1[7:4]}), 1'b1, 1'b0, STATUS_OK);
                  push_result((group_pos == 2'd2) ? b64_char({b1[3:0], 2'b00}) : PAD_CHAR,
                              1'b1, 1'b0, STATUS_OK);
                  push_result(PAD_CHAR, 1'b1, 1'b1, STATUS_OK);
               end
               clear_message();
            end
         end else begin
            group_pos++;
            // after a pad or a bad character only the count advances
            if (!pad_seen && !bad_seen) begin
               if (b == PAD_CHAR) begin
                  pad_seen = 1;
               end else begin
                  v = b64_value(b);
                  if (v < 0) begin
                     bad_seen = 1;
                     if (!l) push_result(8'h00, 1'b0, 1'b0, STATUS_BAD_CHAR);
                  end else begin
                     held_bits  = {held_bits[9:0], 6'(v)};
                     held_count += 6;
                     if (held_count >= 8) begin
                        push_result(8'(held_bits >> (held_count - 8)), 1'b1, 1'b0, STATUS_OK);
                        held_count -= 8;
                        held_bits  &= (16'd1 << held_count) - 16'd1;
                     end
                  end
               end
            end
            // closing status beat
            if (l) begin
               if (group_pos != 2'd0) st = STATUS_BAD_LEN;
               else if (bad_seen)     st = STATUS_BAD_CHAR;
               else                   st = STATUS_OK;
               push_result(8'h00, 1'b0, 1'b1, st);
               clear_message();
            end
         end
      endfunction

      function void compare_result(result_type got);
         result_type want;
         if (coded_out.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected beat: byte %02h valid %0d last %0d status %0d",
                        got.out_byte, got.out_valid, got.out_last, got.status);
            return;
         end
         want = coded_out.pop_front();
         if (got.out_byte !== want.out_byte || got.out_valid !== want.out_valid ||
             got.out_last !== want.out_last || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("mismatch: want byte %02h valid %0d last %0d status %0d, %s",
                        want.out_byte, want.out_valid, want.out_last, want.status,
                        $sformatf("got byte %02h valid %0d last %0d status %0d",
                                  got.out_byte, got.out_valid, got.out_last, got.status));
         end
      endfunction
   endclass

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       csr_write_en   = 1'b0;
   logic       csr_write_data = 1'b0;
   logic       req_valid      = 1'b0;
   logic [7:0] req_data_byte  = 8'h00;
   logic       req_last       = 1'b0;
   logic       rsp_stall      = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_valid;
   logic       rsp_out_last;
   logic [1:0] rsp_status;

   codec_scoreboard codec_sb = new();

   bit steady        = 0;
   int long_hold_req = 0;
   int long_hold_ack = 0;
   int hold_left     = 0;
   int stall_left    = 0;
   int cycle_count   = 0;

   base64_stream_codec_unit dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_valid  (rsp_out_valid),
      .rsp_out_last   (rsp_out_last),
      .rsp_status     (rsp_status)
   );

   always #5 clock = ~clock;

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   // Check accepted result beats, then pick the stall for the next cycle
   always @(posedge clock) begin
      result_type got;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.out_byte  = rsp_out_byte;
            got.out_valid = rsp_out_valid;
            got.out_last  = rsp_out_last;
            got.status    = rsp_status;
            codec_sb.compare_result(got);
         end
         if (long_hold_req != long_hold_ack) begin
            long_hold_ack = long_hold_req;
            hold_left     = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (steady) begin
            stall_left = 0;
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // Hard stop on a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Offer one beat, optionally after an idle gap; returns at the accepting edge
   task automatic send_beat(input logic [7:0] b, input logic l);
      int gap;
      gap = 0;
      if (!steady && $urandom_range(0, 2) == 0) gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last      <= l;
      do @(posedge clock); while (!(req_valid && !req_stall));
      codec_sb.predict_from_byte(b, l);
   endtask

   task automatic send_message(input byte_queue_type msg);
      for (int i = 0; i < msg.size(); i++)
         send_beat(msg[i], (i == msg.size() - 1));
   endtask

   // Hold the input off until every expected beat is out and the block settles
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (codec_sb.coded_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      csr_write_en   <= 1'b1;
      csr_write_data <= m;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      codec_sb.set_mode(m);
   endtask

   function automatic byte_queue_type from_text(input string s);
      byte_queue_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   // Well-formed padded text for a byte string
   function automatic byte_queue_type to_base64(input byte_queue_type raw);
      byte_queue_type txt;
      logic [23:0]    grp;
      int             k;
      for (int i = 0; i < raw.size(); i += 3) begin
         k = raw.size() - i;
         grp = {raw[i], 16'h0000};
         if (k > 1) grp[15:8] = raw[i+1];
         if (k > 2) grp[7:0]  = raw[i+2];
         txt.push_back(codec_sb.b64_char(grp[23:18]));
         txt.push_back(codec_sb.b64_char(grp[17:12]));
         txt.push_back((k > 1) ? codec_sb.b64_char(grp[11:6]) : PAD_CHAR);
         txt.push_back((k > 2) ? codec_sb.b64_char(grp[5:0]) : PAD_CHAR);
      end
      return txt;
   endfunction

   task automatic random_encode_message();
      byte_queue_type msg;
      int             n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      repeat (n) msg.push_back(8'($urandom_range(0, 255)));
      send_message(msg);
   endtask

   // Mostly valid text; some corrupted, truncated, over-long, padded early or noise
   task automatic random_decode_message();
      byte_queue_type raw;
      byte_queue_type txt;
      int             n;
      int             pos;
      n = $urandom_range(1, 7);
      repeat (n) raw.push_back(8'($urandom_range(0, 255)));
      txt = to_base64(raw);
      pos = $urandom_range(0, txt.size() - 1);
      case ($urandom_range(0, 9))
         0: txt[pos] = 8'($urandom_range(0, 255));
         1: if (txt.size() > 1) void'(txt.pop_back());
         2: txt.push_back(codec_sb.b64_char(6'($urandom_range(0, 63))));
         3: txt[pos] = PAD_CHAR;
         4: begin
            txt.delete();
            repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
      send_message(txt);
   endtask

   initial begin
      byte_queue_type msg;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Encode from the reset mode: one, two and three byte messages
      msg = {8'h00};
      send_message(msg);
      msg = {8'hff, 8'hff};
      send_message(msg);
      msg = {8'h00, 8'hff, 8'h80};
      send_message(msg);
      // leave a partial group pending; the mode write must drop it
      send_beat(8'h4d, 1'b0);
      send_beat(8'h61, 1'b0);
      wait_idle();
      write_mode(MODE_DECODE);

      // Decode: double pad, junk after pad, bad char mid-message, short, high byte
      send_message(from_text("TQ=="));
      send_message(from_text("QU=*"));
      send_message(from_text("AB*D"));
      send_message(from_text("Zm9"));
      msg = {8'hff};
      send_message(msg);
      wait_idle();
      write_mode(MODE_ENCODE);

      // Random encode; one long receiver hold while the sender keeps going
      for (int i = 0; i < 25; i++) begin
         if (i == 8) long_hold_req++;
         random_encode_message();
      end
      wait_idle();
      write_mode(MODE_DECODE);

      // Random decode, first a stretch without any idling
      steady = 1;
      for (int i = 0; i < 8; i++) random_decode_message();
      steady = 0;
      for (int i = 0; i < 27; i++) random_decode_message();
      wait_idle();
      write_mode(MODE_ENCODE);

      steady = 1;
      for (int i = 0; i < 5; i++) random_encode_message();
      steady = 0;
      wait_idle();

      if (codec_sb.mismatches == 0 && codec_sb.coded_out.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
